// ===== hdl/segregated_free_list_page_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Property shorthands for the allocator port checker.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SFPA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("sfpa assertion failed");

// next-cycle implication
`define SFPA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("sfpa assertion failed");

`endif

// ===== hdl/sfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page allocator package
// Sizes, codes, tag layout and helper functions.
// ----------------------------------------------------------------------------
package sfpa_pkg;

  localparam int NUM_PAGES   = 4096;
  localparam int REGION_LOG2 = 10;
  localparam int NUM_LISTS   = 16;
  localparam int REGION      = 1 << REGION_LOG2;

  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int LIST_W = 4;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  size;
    logic [LIST_W-1:0] list;
    logic [PAGE_W-1:0] prev;
    logic [PAGE_W-1:0] next;
  } tag_t;

  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] addr;
    tag_t              data;
  } tag_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] addr;
    logic              data;
  } fm_wr_t;

  function automatic logic [LIST_W-1:0] flog2(input logic [CNT_W-1:0] x);
    logic [LIST_W-1:0] r;
    r = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (x[i]) r = LIST_W'(i);
    end
    return r;
  endfunction

  function automatic logic [LIST_W-1:0] list_of(input logic [CNT_W-1:0] size);
    logic [LIST_W-1:0] l;
    l = flog2(size);
    if (int'(l) > NUM_LISTS - 1) l = LIST_W'(NUM_LISTS - 1);
    return l;
  endfunction

endpackage

// ===== hdl/sfpa_store.sv =====
// ----------------------------------------------------------------------------
// Page allocator store
// Boundary tag memory and per-page free map, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module sfpa_store (
  input  logic                          clk,
  input  sfpa_pkg::tag_wr_t             tag_wr,
  input  logic [sfpa_pkg::PAGE_W-1:0]   tag_raddr,
  output sfpa_pkg::tag_t                tag_rdata,
  input  sfpa_pkg::fm_wr_t              fm_wr,
  input  logic [sfpa_pkg::PAGE_W-1:0]   fm_raddr,
  output logic                          fm_rdata
);
  import sfpa_pkg::*;

  tag_t tag_mem [NUM_PAGES];
  logic fm_mem  [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (tag_wr.en) begin
      tag_mem[tag_wr.addr] <= tag_wr.data;
    end
    tag_rdata <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (fm_wr.en) begin
      fm_mem[fm_wr.addr] <= fm_wr.data;
    end
    fm_rdata <= fm_mem[fm_raddr];
  end

endmodule

// ===== hdl/segregated_free_list_page_allocator_core.sv =====
// Init sweeps the free map, then lays out each region; alloc searches the lists, unlinks the run,
// files any remainder and marks each granted page; release checks and marks each page, then merges.
// Throughput: one command at a time, busy high until its word is strobed.
// Reset: free map cleared by a sweep over every page, busy high meanwhile, no word.
// ----------------------------------------------------------------------------
// Segregated free list page allocator core
// Sequencer over tag memory and free map: init, allocate, release.
// ----------------------------------------------------------------------------
module segregated_free_list_page_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [sfpa_pkg::PAGE_W-1:0]   in_page_start,
  input  logic [sfpa_pkg::CNT_W-1:0]    in_page_count,
  input  logic [sfpa_pkg::CNT_W-1:0]    in_min_count,
  output logic                          out_strobe,
  output logic [sfpa_pkg::PAGE_W-1:0]   out_grant_start,
  output logic [sfpa_pkg::CNT_W-1:0]    out_granted_pages,
  output logic [1:0]                    out_status,
  output logic [sfpa_pkg::CNT_W-1:0]    out_used_pages,
  output logic [sfpa_pkg::CNT_W-1:0]    out_free_pages,
  input  logic                          cfg_we,
  input  logic [sfpa_pkg::CNT_W-1:0]    cfg_wdata
);
  import sfpa_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_REG  = 5'd2;
  localparam logic [4:0] S_INS0 = 5'd3;
  localparam logic [4:0] S_INS1 = 5'd4;
  localparam logic [4:0] S_INS2 = 5'd5;
  localparam logic [4:0] S_RM0  = 5'd6;
  localparam logic [4:0] S_RM1  = 5'd7;
  localparam logic [4:0] S_RM2  = 5'd8;
  localparam logic [4:0] S_RM3  = 5'd9;
  localparam logic [4:0] S_RM4  = 5'd10;
  localparam logic [4:0] S_RL0  = 5'd11;
  localparam logic [4:0] S_CK0  = 5'd12;
  localparam logic [4:0] S_CK1  = 5'd13;
  localparam logic [4:0] S_MARK = 5'd14;
  localparam logic [4:0] S_RL1  = 5'd15;
  localparam logic [4:0] S_RL2  = 5'd16;
  localparam logic [4:0] S_RL3  = 5'd17;
  localparam logic [4:0] S_RL4  = 5'd18;
  localparam logic [4:0] S_RL5  = 5'd19;
  localparam logic [4:0] S_RL6  = 5'd20;
  localparam logic [4:0] S_RL7  = 5'd21;
  localparam logic [4:0] S_AL0  = 5'd22;
  localparam logic [4:0] S_AS1  = 5'd23;
  localparam logic [4:0] S_AS1W = 5'd24;
  localparam logic [4:0] S_AS2  = 5'd25;
  localparam logic [4:0] S_GR0  = 5'd26;
  localparam logic [4:0] S_GR1  = 5'd27;
  localparam logic [4:0] S_GR2  = 5'd28;
  localparam logic [4:0] S_GR3  = 5'd29;
  localparam logic [4:0] S_DONE = 5'd30;

  localparam int LI_W = LIST_W + 1;

  logic [4:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [PAGE_W-1:0] pstart_r, pstart_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, minc_r, minc_nxt;
  logic [CNT_W-1:0]  cfg_pages_r, managed_r, managed_nxt, used_r, used_nxt;
  logic [PAGE_W-1:0] gstart_r, gstart_nxt;
  logic [CNT_W-1:0]  gcount_r, gcount_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              rsp_r, rsp_nxt;
  logic [PAGE_W-1:0] arg_start_r, arg_start_nxt;
  logic [CNT_W-1:0]  arg_size_r, arg_size_nxt;
  logic [LIST_W-1:0] ins_l_r, ins_l_nxt;
  logic [PAGE_W-1:0] ins_head_r, ins_head_nxt;
  logic [PAGE_W-1:0] rm_prev_r, rm_prev_nxt, rm_next_r, rm_next_nxt;
  logic [CNT_W-1:0]  rm_size_r, rm_size_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt, last_r, last_nxt;
  logic              mval_r, mval_nxt;
  logic [PAGE_W-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [LI_W-1:0]   li_r, li_nxt, want_r, want_nxt, minl_r, minl_nxt;
  logic [PAGE_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  rs_r, rs_nxt, lim_r, lim_nxt;

  logic [PAGE_W-1:0] heads_r [NUM_LISTS];
  logic              hd_we, hd_clr;
  logic [LIST_W-1:0] hd_widx, hd_ridx;
  logic [PAGE_W-1:0] hd_wdata, hd_rdata;

  tag_wr_t           tag_wr;
  logic [PAGE_W-1:0] tag_raddr;
  tag_t              tag_rdata;
  fm_wr_t            fm_wr;
  logic [PAGE_W-1:0] fm_raddr;
  logic              fm_rdata;

  sfpa_store u_store (
    .clk       (clk),
    .tag_wr    (tag_wr),
    .tag_raddr (tag_raddr),
    .tag_rdata (tag_rdata),
    .fm_wr     (fm_wr),
    .fm_raddr  (fm_raddr),
    .fm_rdata  (fm_rdata)
  );

  assign hd_rdata = heads_r[hd_ridx];

  always_comb begin
    tag_t              t;
    logic [LIST_W-1:0] l;
    logic [CNT_W-1:0]  pg, g, c1;
    logic [CNT_W:0]    s14, e14;
    logic [PAGE_W-1:0] h;
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pstart_nxt    = pstart_r;
    cnt_nxt       = cnt_r;
    minc_nxt      = minc_r;
    managed_nxt   = managed_r;
    used_nxt      = used_r;
    gstart_nxt    = gstart_r;
    gcount_nxt    = gcount_r;
    status_nxt    = status_r;
    rsp_nxt       = rsp_r;
    arg_start_nxt = arg_start_r;
    arg_size_nxt  = arg_size_r;
    ins_l_nxt     = ins_l_r;
    ins_head_nxt  = ins_head_r;
    rm_prev_nxt   = rm_prev_r;
    rm_next_nxt   = rm_next_r;
    rm_size_nxt   = rm_size_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    mval_nxt      = mval_r;
    run_start_nxt = run_start_r;
    run_cnt_nxt   = run_cnt_r;
    li_nxt        = li_r;
    want_nxt      = want_r;
    minl_nxt      = minl_r;
    cand_nxt      = cand_r;
    rs_nxt        = rs_r;
    lim_nxt       = lim_r;
    hd_we         = 1'b0;
    hd_clr        = 1'b0;
    hd_widx       = '0;
    hd_wdata      = '0;
    hd_ridx       = '0;
    tag_wr        = '0;
    tag_raddr     = '0;
    fm_wr         = '0;
    fm_raddr      = '0;
    t             = tag_rdata;
    l             = '0;
    pg            = '0;
    g             = '0;
    c1            = '0;
    s14           = '0;
    e14           = '0;
    h             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pstart_nxt = in_page_start;
          cnt_nxt    = in_page_count;
          minc_nxt   = in_min_count;
          gstart_nxt = '0;
          gcount_nxt = '0;
          status_nxt = ST_OK;
          rsp_nxt    = 1'b1;
          unique case (in_command)
            CMD_INIT: begin
              pg = (int'(cfg_pages_r) > NUM_PAGES) ? CNT_W'(NUM_PAGES) : cfg_pages_r;
              s14 = {1'b0, pg} + (CNT_W+1)'(REGION - 1);
              managed_nxt = pg;
              used_nxt    = CNT_W'(s14 >> REGION_LOG2);
              lim_nxt     = pg;
              idx_nxt     = '0;
              hd_clr      = 1'b1;
              state_nxt   = S_CLR;
            end
            CMD_ALLOC:   state_nxt = S_AL0;
            CMD_RELEASE: state_nxt = S_RL0;
            default: begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_CLR: begin
        fm_wr.en   = 1'b1;
        fm_wr.addr = idx_r;
        fm_wr.data = ({1'b0, idx_r} < lim_r) && (idx_r[REGION_LOG2-1:0] != '0);
        if (int'(idx_r) == NUM_PAGES - 1) begin
          rs_nxt    = '0;
          state_nxt = S_REG;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_REG: begin
        if (rs_r < lim_r) begin
          s14 = {1'b0, rs_r} + (CNT_W+1)'(REGION);
          e14 = (s14 > {1'b0, lim_r}) ? {1'b0, lim_r} : s14;
          c1  = CNT_W'(e14 - {1'b0, rs_r});
          rs_nxt = CNT_W'(s14);
          if (c1 > CNT_W'(1)) begin
            arg_start_nxt = rs_r[PAGE_W-1:0] + 1'b1;
            arg_size_nxt  = c1 - 1'b1;
            ret_nxt       = S_REG;
            state_nxt     = S_INS0;
          end
        end else begin
          state_nxt = rsp_r ? S_DONE : S_IDLE;
        end
      end

      S_INS0: begin
        l            = list_of(arg_size_r);
        hd_ridx      = l;
        ins_l_nxt    = l;
        ins_head_nxt = hd_rdata;
        tag_wr.en    = 1'b1;
        tag_wr.addr  = arg_start_r;
        tag_wr.data  = '{size: arg_size_r, list: l, prev: '0, next: hd_rdata};
        state_nxt    = S_INS1;
      end

      S_INS1: begin
        c1          = CNT_W'({1'b0, arg_start_r}) + arg_size_r - 1'b1;
        tag_wr.en   = 1'b1;
        tag_wr.addr = c1[PAGE_W-1:0];
        tag_wr.data = '{size: arg_size_r, list: ins_l_r, prev: '0, next: ins_head_r};
        if (ins_head_r != '0) begin
          tag_raddr = ins_head_r;
          state_nxt = S_INS2;
        end else begin
          hd_we     = 1'b1;
          hd_widx   = ins_l_r;
          hd_wdata  = arg_start_r;
          state_nxt = ret_r;
        end
      end

      S_INS2: begin
        t.prev      = arg_start_r;
        tag_wr.en   = 1'b1;
        tag_wr.addr = ins_head_r;
        tag_wr.data = t;
        hd_we       = 1'b1;
        hd_widx     = ins_l_r;
        hd_wdata    = arg_start_r;
        state_nxt   = ret_r;
      end

      S_RM0: begin
        tag_raddr = arg_start_r;
        state_nxt = S_RM1;
      end

      S_RM1: begin
        rm_prev_nxt = t.prev;
        rm_next_nxt = t.next;
        rm_size_nxt = t.size;
        l = (int'(t.list) < NUM_LISTS) ? t.list : '0;
        if (t.prev != '0) begin
          tag_raddr = t.prev;
          state_nxt = S_RM2;
        end else begin
          hd_we     = 1'b1;
          hd_widx   = l;
          hd_wdata  = t.next;
          state_nxt = S_RM3;
        end
      end

      S_RM2: begin
        t.next      = rm_next_r;
        tag_wr.en   = 1'b1;
        tag_wr.addr = rm_prev_r;
        tag_wr.data = t;
        state_nxt   = S_RM3;
      end

      S_RM3: begin
        if (rm_next_r != '0) begin
          tag_raddr = rm_next_r;
          state_nxt = S_RM4;
        end else begin
          state_nxt = ret_r;
        end
      end

      S_RM4: begin
        t.prev      = rm_prev_r;
        tag_wr.en   = 1'b1;
        tag_wr.addr = rm_next_r;
        tag_wr.data = t;
        state_nxt   = ret_r;
      end

      S_RL0: begin
        s14 = {2'b0, pstart_r} + {1'b0, cnt_r};
        if (pstart_r == '0 || cnt_r == '0 || s14 > {1'b0, managed_r}) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          c1        = CNT_W'(s14) - 1'b1;
          idx_nxt   = pstart_r;
          last_nxt  = c1[PAGE_W-1:0];
          state_nxt = S_CK0;
        end
      end

      S_CK0: begin
        fm_raddr  = idx_r;
        state_nxt = S_CK1;
      end

      S_CK1: begin
        if (fm_rdata) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else if (idx_r == last_r) begin
          idx_nxt   = pstart_r;
          mval_nxt  = 1'b1;
          ret_nxt   = S_RL1;
          state_nxt = S_MARK;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CK0;
        end
      end

      S_MARK: begin
        fm_wr.en   = 1'b1;
        fm_wr.addr = idx_r;
        fm_wr.data = mval_r;
        if (idx_r == last_r) begin
          state_nxt = ret_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_RL1: begin
        used_nxt      = used_r - cnt_r;
        run_start_nxt = pstart_r;
        run_cnt_nxt   = cnt_r;
        fm_raddr      = pstart_r - 1'b1;
        state_nxt     = S_RL2;
      end

      S_RL2: begin
        if (fm_rdata) begin
          tag_raddr = run_start_r - 1'b1;
          state_nxt = S_RL3;
        end else begin
          state_nxt = S_RL4;
        end
      end

      S_RL3: begin
        h             = run_start_r - t.size[PAGE_W-1:0];
        arg_start_nxt = h;
        run_start_nxt = h;
        run_cnt_nxt   = run_cnt_r + t.size;
        ret_nxt       = S_RL4;
        state_nxt     = S_RM0;
      end

      S_RL4: begin
        c1 = CNT_W'({1'b0, run_start_r}) + run_cnt_r;
        if (c1 < managed_r) begin
          fm_raddr  = c1[PAGE_W-1:0];
          state_nxt = S_RL5;
        end else begin
          state_nxt = S_RL7;
        end
      end

      S_RL5: begin
        c1 = CNT_W'({1'b0, run_start_r}) + run_cnt_r;
        if (fm_rdata) begin
          arg_start_nxt = c1[PAGE_W-1:0];
          ret_nxt       = S_RL6;
          state_nxt     = S_RM0;
        end else begin
          state_nxt = S_RL7;
        end
      end

      S_RL6: begin
        run_cnt_nxt = run_cnt_r + rm_size_r;
        state_nxt   = S_RL7;
      end

      S_RL7: begin
        arg_start_nxt = run_start_r;
        arg_size_nxt  = run_cnt_r;
        ret_nxt       = S_DONE;
        state_nxt     = S_INS0;
      end

      S_AL0: begin
        if (cnt_r == '0 || int'(cnt_r) > NUM_PAGES || minc_r == '0) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          want_nxt = (cnt_r > CNT_W'(1)) ? LI_W'(flog2(cnt_r - 1'b1)) + 1'b1 : '0;
          minl_nxt = (minc_r > CNT_W'(1)) ? LI_W'(flog2(minc_r - 1'b1)) + 1'b1 : '0;
          li_nxt   = (cnt_r > CNT_W'(1)) ? LI_W'(flog2(cnt_r - 1'b1)) + 1'b1 : '0;
          state_nxt = S_AS1;
        end
      end

      S_AS1: begin
        if (int'(li_r) >= NUM_LISTS) begin
          li_nxt    = (int'(want_r) < NUM_LISTS) ? want_r : LI_W'(NUM_LISTS);
          state_nxt = S_AS2;
        end else begin
          hd_ridx = li_r[LIST_W-1:0];
          if (hd_rdata != '0) begin
            cand_nxt  = hd_rdata;
            tag_raddr = hd_rdata;
            state_nxt = S_AS1W;
          end else begin
            li_nxt = li_r + 1'b1;
          end
        end
      end

      S_AS1W: begin
        if (t.size >= cnt_r) begin
          gstart_nxt = cand_r;
          state_nxt  = S_GR0;
        end else begin
          li_nxt    = li_r + 1'b1;
          state_nxt = S_AS1;
        end
      end

      S_AS2: begin
        if (li_r > minl_r) begin
          h       = '0;
          hd_ridx = LIST_W'(li_r - 1'b1);
          if (hd_rdata != h) begin
            cand_nxt   = hd_rdata;
            gstart_nxt = hd_rdata;
            state_nxt  = S_GR0;
          end else begin
            li_nxt = li_r - 1'b1;
          end
        end else begin
          status_nxt = ST_NONE;
          state_nxt  = S_DONE;
        end
      end

      S_GR0: begin
        arg_start_nxt = cand_r;
        ret_nxt       = S_GR1;
        state_nxt     = S_RM0;
      end

      S_GR1: begin
        g          = (rm_size_r < cnt_r) ? rm_size_r : cnt_r;
        gcount_nxt = g;
        if (rm_size_r > g) begin
          arg_start_nxt = cand_r + g[PAGE_W-1:0];
          arg_size_nxt  = rm_size_r - g;
          ret_nxt       = S_GR2;
          state_nxt     = S_INS0;
        end else begin
          state_nxt = S_GR2;
        end
      end

      S_GR2: begin
        c1        = CNT_W'({1'b0, cand_r}) + gcount_r - 1'b1;
        idx_nxt   = cand_r;
        last_nxt  = c1[PAGE_W-1:0];
        mval_nxt  = 1'b0;
        ret_nxt   = S_GR3;
        state_nxt = S_MARK;
      end

      S_GR3: begin
        used_nxt  = used_r + gcount_r;
        state_nxt = S_DONE;
      end

      S_DONE: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_IDLE;
      cfg_pages_r <= CNT_W'(NUM_PAGES);
      managed_r   <= '0;
      used_r      <= '0;
      rsp_r       <= 1'b0;
      idx_r       <= '0;
      lim_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cfg_pages_r <= cfg_we ? cfg_wdata : cfg_pages_r;
      managed_r   <= managed_nxt;
      used_r      <= used_nxt;
      rsp_r       <= rsp_nxt;
      idx_r       <= idx_nxt;
      lim_r       <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pstart_r    <= pstart_nxt;
    cnt_r       <= cnt_nxt;
    minc_r      <= minc_nxt;
    gstart_r    <= gstart_nxt;
    gcount_r    <= gcount_nxt;
    status_r    <= status_nxt;
    arg_start_r <= arg_start_nxt;
    arg_size_r  <= arg_size_nxt;
    ins_l_r     <= ins_l_nxt;
    ins_head_r  <= ins_head_nxt;
    rm_prev_r   <= rm_prev_nxt;
    rm_next_r   <= rm_next_nxt;
    rm_size_r   <= rm_size_nxt;
    last_r      <= last_nxt;
    mval_r      <= mval_nxt;
    run_start_r <= run_start_nxt;
    run_cnt_r   <= run_cnt_nxt;
    li_r        <= li_nxt;
    want_r      <= want_nxt;
    minl_r      <= minl_nxt;
    cand_r      <= cand_nxt;
    rs_r        <= rs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || hd_clr) begin
      for (int i = 0; i < NUM_LISTS; i++) heads_r[i] <= '0;
    end else if (hd_we) begin
      heads_r[hd_widx] <= hd_wdata;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = (state_r == S_DONE);
  assign out_grant_start   = gstart_r;
  assign out_granted_pages = gcount_r;
  assign out_status        = status_r;
  assign out_used_pages    = used_r;
  assign out_free_pages    = managed_r - used_r;

endmodule

// ===== hdl/sfpa_chk.sv =====
// ----------------------------------------------------------------------------
// Page allocator port checker
// Port-level properties of the command and result handshake.
// ----------------------------------------------------------------------------
`include "segregated_free_list_page_allocator_core_assert.svh"

module sfpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [12:0] out_granted_pages
);
  import sfpa_pkg::*;

  `SFPA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SFPA_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `SFPA_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe && !busy)
  `SFPA_ASSERT_NOW(a_status_code, clk, rst_n, out_strobe, out_status <= ST_RANGE)
  `SFPA_ASSERT_NOW(a_fail_no_grant, clk, rst_n, out_strobe && out_status != ST_OK, out_granted_pages == '0)

endmodule

bind segregated_free_list_page_allocator_core sfpa_chk u_sfpa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_granted_pages (out_granted_pages)
);

// ===== verif/sfpa_checker.sv =====
// ----------------------------------------------------------------------------
// Page allocator checker
// Watches the command, result and register ports of the allocator and keeps
// its own model of the free lists, boundary tags and free map. Each
// accepted command is predicted and every strobed word is compared, field by
// field, against the oldest prediction.
// ----------------------------------------------------------------------------
module sfpa_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic [sfpa_pkg::PAGE_W-1:0] in_page_start,
  input  logic [sfpa_pkg::CNT_W-1:0]  in_page_count,
  input  logic [sfpa_pkg::CNT_W-1:0]  in_min_count,
  input  logic                        out_strobe,
  input  logic [sfpa_pkg::PAGE_W-1:0] out_grant_start,
  input  logic [sfpa_pkg::CNT_W-1:0]  out_granted_pages,
  input  logic [1:0]                  out_status,
  input  logic [sfpa_pkg::CNT_W-1:0]  out_used_pages,
  input  logic [sfpa_pkg::CNT_W-1:0]  out_free_pages,
  input  logic                        cfg_we,
  input  logic [sfpa_pkg::CNT_W-1:0]  cfg_wdata,
  output int                          mismatches,
  output int                          words_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfpa_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0] grant_start;
    logic [CNT_W-1:0]  granted;
    logic [1:0]        status;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } alloc_word_t;

  alloc_word_t owed_words[$];

  int  tg_size[NUM_PAGES];
  int  tg_list[NUM_PAGES];
  int  tg_prev[NUM_PAGES];
  int  tg_next[NUM_PAGES];
  bit  page_free[NUM_PAGES];
  int  free_heads[NUM_LISTS];
  int  in_use;
  int  managed_now;
  int  managed_reg;

  function automatic int idx(int p);
    return (p >= 0 && p < NUM_PAGES) ? p : 0;
  endfunction

  function automatic bit free_at(int p);
    return p >= 0 && p < NUM_PAGES && page_free[p];
  endfunction

  function automatic int log2_floor(int x);
    int r;
    r = 0;
    while (x > 1) begin
      x = x >> 1;
      r++;
    end
    return r;
  endfunction

  function automatic int bucket(int size);
    int l;
    l = log2_floor(size);
    return l > NUM_LISTS - 1 ? NUM_LISTS - 1 : l;
  endfunction

  function automatic void set_free(int s, int n, bit v);
    for (int i = 0; i < n; i++)
      if (s + i < NUM_PAGES) page_free[s + i] = v;
  endfunction

  function automatic void tag_write(int p, int size, int l, int h);
    tg_size[idx(p)] = size;
    tg_list[idx(p)] = l;
    tg_prev[idx(p)] = 0;
    tg_next[idx(p)] = h;
  endfunction

  function automatic void push_run(int s, int size);
    int l, h;
    l = bucket(size);
    h = free_heads[l];
    tag_write(s, size, l, h);
    tag_write(s + size - 1, size, l, h);
    if (h != 0) tg_prev[idx(h)] = s;
    free_heads[l] = s;
  endfunction

  function automatic int unlink_run(int s);
    int i, l, p, n;
    i = idx(s);
    l = tg_list[i] < NUM_LISTS ? tg_list[i] : 0;
    p = tg_prev[i];
    n = tg_next[i];
    if (p != 0) tg_next[idx(p)] = n;
    else free_heads[l] = n;
    if (n != 0) tg_prev[idx(n)] = p;
    return tg_size[i];
  endfunction

  function automatic void release_run(int s, int n);
    int sz, right;
    set_free(s, n, 1'b1);
    in_use -= n;
    if (s >= 1 && free_at(s - 1)) begin
      sz = tg_size[idx(s - 1)];
      void'(unlink_run(s - sz));
      s = s - sz;
      n += sz;
    end
    right = s + n;
    if (right < managed_now && free_at(right)) n += unlink_run(right);
    push_run(s, n);
  endfunction

  function automatic int take_run(int s, int n);
    int sz, g;
    sz = unlink_run(s);
    g = sz < n ? sz : n;
    if (sz > g) push_run(s + g, sz - g);
    set_free(s, g, 1'b0);
    in_use += g;
    return g;
  endfunction

  function automatic void clear_model();
    foreach (free_heads[i]) free_heads[i] = 0;
    foreach (page_free[i]) page_free[i] = 1'b0;
  endfunction

  function automatic void lay_out();
    int pages, e;
    pages = managed_reg > NUM_PAGES ? NUM_PAGES : managed_reg;
    clear_model();
    managed_now = pages;
    in_use = pages;
    for (int rs = 0; rs < pages; rs += REGION) begin
      e = rs + REGION > pages ? pages : rs + REGION;
      if (e - rs > 1) release_run(rs + 1, e - rs - 1);
    end
  endfunction

  function automatic alloc_word_t predict(logic [1:0] cmd, int ps, int cnt, int minc);
    alloc_word_t w;
    int gs, gc, want, minl, h;
    bit found, ok;
    gs = 0;
    gc = 0;
    w.status = ST_OK;
    if (cmd == CMD_INIT) begin
      lay_out();
    end else if (cmd == CMD_ALLOC) begin
      if (cnt == 0 || cnt > NUM_PAGES || minc == 0) begin
        w.status = ST_RANGE;
      end else begin
        want = cnt > 1 ? log2_floor(cnt - 1) + 1 : 0;
        minl = minc > 1 ? log2_floor(minc - 1) + 1 : 0;
        found = 1'b0;
        for (int i = want; i < NUM_LISTS && !found; i++) begin
          h = free_heads[i];
          if (h != 0 && tg_size[idx(h)] >= cnt) begin
            gs = h;
            gc = take_run(h, cnt);
            found = 1'b1;
          end
        end
        for (int i = (want < NUM_LISTS ? want : NUM_LISTS); i > minl && !found; i--) begin
          h = free_heads[i - 1];
          if (h != 0) begin
            gs = h;
            gc = take_run(h, cnt);
            found = 1'b1;
          end
        end
        if (!found) w.status = ST_NONE;
      end
    end else if (cmd == CMD_RELEASE) begin
      ok = ps != 0 && cnt != 0 && ps + cnt <= managed_now;
      for (int i = 0; ok && i < cnt; i++)
        if (free_at(ps + i)) ok = 1'b0;
      if (ok) release_run(ps, cnt);
      else w.status = ST_RANGE;
    end else begin
      w.status = ST_RANGE;
    end
    w.grant_start = gs[PAGE_W-1:0];
    w.granted     = gc[CNT_W-1:0];
    w.used        = in_use[CNT_W-1:0];
    w.free        = CNT_W'(managed_now - in_use);
    return w;
  endfunction

  function automatic void note_mismatch(string what, alloc_word_t e, alloc_word_t a);
    if (mismatches < 10)
      $display({"%0t: %s exp gs=%0d gp=%0d st=%0d used=%0d free=%0d, ",
                "got gs=%0d gp=%0d st=%0d used=%0d free=%0d"},
               $realtime, what, e.grant_start, e.granted, e.status, e.used, e.free,
               a.grant_start, a.granted, a.status, a.used, a.free);
    mismatches++;
  endfunction

  initial begin
    mismatches = 0;
    words_owed = 0;
    managed_reg = NUM_PAGES;
    managed_now = 0;
    in_use = 0;
    clear_model();
  end

  always @(posedge clk) begin
    alloc_word_t seen, exp;
    if (!rst_n) begin
      managed_reg = NUM_PAGES;
      managed_now = 0;
      in_use = 0;
      clear_model();
      owed_words.delete();
    end else begin
      if (out_strobe) begin
        seen = '{out_grant_start, out_granted_pages, out_status, out_used_pages,
                 out_free_pages};
        if (owed_words.size() == 0) begin
          note_mismatch("unexpected word", '0, seen);
        end else begin
          exp = owed_words.pop_front();
          if (seen.grant_start !== exp.grant_start || seen.granted !== exp.granted ||
              seen.status !== exp.status || seen.used !== exp.used ||
              seen.free !== exp.free)
            note_mismatch("word mismatch", exp, seen);
        end
      end
      if (start && !busy)
        owed_words = {owed_words, predict(in_command, int'(in_page_start),
                                          int'(in_page_count), int'(in_min_count))};
      if (cfg_we) managed_reg = int'(cfg_wdata);
    end
    words_owed = owed_words.size();
  end

endmodule

// ===== verif/tb_segregated_free_list_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Page allocator testbench
// Drives init, allocate and release commands through several store sizes:
// a directed opening, then random traffic of allocations and of releases of
// grants it has seen, whole runs and partial, and some malformed requests.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_segregated_free_list_page_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sfpa_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic [PAGE_W-1:0] in_page_start;
  logic [CNT_W-1:0]  in_page_count;
  logic [CNT_W-1:0]  in_min_count;
  logic              out_strobe;
  logic [PAGE_W-1:0] out_grant_start;
  logic [CNT_W-1:0]  out_granted_pages;
  logic [1:0]        out_status;
  logic [CNT_W-1:0]  out_used_pages;
  logic [CNT_W-1:0]  out_free_pages;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  int                mismatches;
  int                words_owed;
  int                cycles;
  int                sent;
  int                run_start[$];
  int                run_len[$];

  segregated_free_list_page_allocator_core dut (.*);
  sfpa_checker chk (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] c, input int ps, input int pc, input int mc);
    while (!(sent >= 500 && sent < 750) && $urandom_range(99) < 18)
      @(posedge clk);
    in_command    <= c;
    in_page_start <= ps[PAGE_W-1:0];
    in_page_count <= pc[CNT_W-1:0];
    in_min_count  <= mc[CNT_W-1:0];
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    start <= 1'b0;
    sent++;
    do @(posedge clk); while (out_strobe !== 1'b1);
    if (c == CMD_INIT && out_status == ST_OK) begin
      run_start.delete();
      run_len.delete();
    end
    if (c == CMD_ALLOC && out_granted_pages != 0) begin
      run_start = {run_start, int'(out_grant_start)};
      run_len   = {run_len, int'(out_granted_pages)};
    end
  endtask

  task automatic write_managed(input int v);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic give_back();
    int k, s, n, part;
    k = $urandom_range(run_start.size() - 1);
    s = run_start[k];
    n = run_len[k];
    run_start.delete(k);
    run_len.delete(k);
    part = $urandom_range(2) == 0 ? $urandom_range(1, n) : n;
    if (part < n) begin
      if ($urandom_range(1)) begin
        run_start = {run_start, s + part};
        run_len   = {run_len, n - part};
      end else begin
        run_start = {run_start, s};
        run_len   = {run_len, n - part};
        s = s + n - part;
      end
    end
    issue(CMD_RELEASE, s, part, $urandom_range(8191));
  endtask

  task automatic random_item();
    int r, pc, mc;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(19))
        0:       pc = $urandom_range(1, NUM_PAGES);
        1, 2, 3: pc = $urandom_range(1, 300);
        default: pc = $urandom_range(1, 16);
      endcase
      case ($urandom_range(3))
        0:       mc = 1;
        1:       mc = $urandom_range(pc + 1, 8191);
        default: mc = $urandom_range(1, pc);
      endcase
      issue(CMD_ALLOC, $urandom_range(4095), pc, mc);
    end else if (r < 80 && run_start.size() > 0) begin
      give_back();
    end else if (r < 83) begin
      issue(CMD_INIT, $urandom_range(4095), $urandom_range(8191), $urandom_range(8191));
    end else begin
      case ($urandom_range(3))
        0: issue(CMD_UNKNOWN, $urandom_range(4095), $urandom_range(8191),
                 $urandom_range(8191));
        1: issue(CMD_ALLOC, $urandom_range(4095), $urandom_range(8191),
                 $urandom_range(1) ? 0 : $urandom_range(8191));
        default: issue(CMD_RELEASE, $urandom_range(4095), $urandom_range(8191),
                       $urandom_range(8191));
      endcase
    end
  endtask

  initial begin
    int settings[8];
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_INIT;
    in_page_start = '0;
    in_page_count = '0;
    in_min_count  = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    sent          = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_managed(NUM_PAGES);
    issue(CMD_INIT, 0, 0, 0);
    issue(CMD_ALLOC, 0, 1, 1);
    issue(CMD_ALLOC, 4095, 4096, 1);
    issue(CMD_ALLOC, 0, 0, 1);
    issue(CMD_ALLOC, 0, 4097, 1);
    issue(CMD_ALLOC, 0, 8191, 8191);
    issue(CMD_ALLOC, 0, 5, 0);
    issue(CMD_ALLOC, 0, 5, 8191);
    issue(CMD_ALLOC, 0, 3, 2);
    issue(CMD_ALLOC, 0, 4096, 4096);
    issue(CMD_RELEASE, 0, 1, 0);
    issue(CMD_RELEASE, 5, 0, 0);
    issue(CMD_RELEASE, 4095, 2, 0);
    issue(CMD_RELEASE, 4095, 1, 0);
    issue(CMD_RELEASE, 1024, 1, 0);
    issue(CMD_UNKNOWN, 4095, 8191, 8191);
    while (run_start.size() > 0) give_back();
    issue(CMD_INIT, 4095, 8191, 8191);

    settings = '{2, 8191, 1, 1025, 0, 300, 4096, 0};
    settings[7] = $urandom_range(2, 4096);
    foreach (settings[i]) begin
      write_managed(settings[i]);
      issue(CMD_INIT, 0, 0, 0);
      repeat (settings[i] < 4 ? 60 : 220) random_item();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && words_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
